// File: design/rpn_char_stack_interpreter_macros.svh
// Assertion helpers for the calculator block.
`ifndef RPN_CHAR_STACK_INTERPRETER_MACROS_SVH
`define RPN_CHAR_STACK_INTERPRETER_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define RPN_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rpn check failed");

// Check an implication in the next cycle.
`define RPN_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rpn check failed");

`endif

// File: design/rpn_pkg.sv
`timescale 1ns / 1ps
package rpn_pkg;

  localparam int unsigned StackDepth = 20;
  localparam int unsigned CntW = $clog2(StackDepth + 1);
  localparam int unsigned DivSteps = 32;

  typedef enum logic [2:0] {
    KIND_NUMBER    = 3'd0,
    KIND_CHAR      = 3'd1,
    KIND_HALT      = 3'd2,
    KIND_UNDERFLOW = 3'd3,
    KIND_DIVZERO   = 3'd4
  } kind_e;

  // Operation applied by every stack cell together.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PUSH = 2'd1,
    CELL_POP  = 2'd2,
    CELL_POP2 = 2'd3
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_DIV  = 2'd1,
    ST_PUSH = 2'd2,
    ST_HALT = 2'd3
  } state_e;

  localparam logic [7:0] ChNl    = 8'd10;
  localparam logic [7:0] ChDol   = 8'h24;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChTilde = 8'h7e;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChStar  = 8'h2a;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChQuery = 8'h3f;

  // Shared control for the cell row.
  typedef struct packed {
    cell_op_e    op;
    logic [31:0] push_val;
  } cell_ctl_t;

endpackage

// File: design/rpn_if.sv
`timescale 1ns / 1ps
interface rpn_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  prog_char;
  logic signed [31:0] read_value;
  modport source (output valid, prog_char, read_value, input ready);
  modport sink (input valid, prog_char, read_value, output ready);
endinterface

interface rpn_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_kind;
  logic signed [31:0] out_value;
  logic [7:0]  out_char;
  modport source (output valid, out_kind, out_value, out_char, input ready);
  modport sink (input valid, out_kind, out_value, out_char, output ready);
endinterface

// File: design/rpn_char_stack_interpreter.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload
// in_if     sink       prog_char, read_value
// out_if    source     out_kind, out_value, out_char
// One character per cycle when not stalled; the stack is a row of shift
// cells, so each push or pop is registered in all cells at once. A digit run
// ended by a non-digit other than '~' is pushed, then that character replays;
// '+', '-', '*' and a zero-divisor '/' or '%' pop in ST_RUN and push in
// ST_PUSH; nonzero divisors wait in ST_DIV for the iterative divider first.
// Reset clears all control; stack cells hold no reset and are only read
// below the count. Input stalls while a result waits, during a replay, and
// in ST_DIV and ST_PUSH. After a halt every transfer is taken and dropped.
module rpn_char_stack_interpreter (
  input  logic clk_i,
  input  logic rst_ni,
  rpn_in_if.sink    in_if,
  rpn_out_if.source out_if
);
  import rpn_pkg::*;
  `include "rpn_char_stack_interpreter_macros.svh"

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     acc_q, acc_d;
  logic            in_num_q, in_num_d, in_text_q, in_text_d, in_cmt_q, in_cmt_d;
  logic [7:0]      pend_q, pend_d;  // character held behind a digit-run push
  logic [31:0]     prv_q, prv_d;    // read value held with that character
  logic            pend_v_q, pend_v_d;
  logic            ov_q, ov_d;
  kind_e           ok_q, ok_d;
  logic [31:0]     oval_q, oval_d;
  logic [7:0]      och_q, och_d;

  cell_ctl_t   ctl;
  logic [31:0] top0, top1, div_res;
  logic        div_start, div_done, div_rem;
  logic        acc_in, can_emit;
  logic [7:0]  c;
  logic        full;

  rpn_stack u_stack (.clk_i(clk_i), .ctl_i(ctl), .top0_o(top0), .top1_o(top1));

  rpn_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .want_rem_i(div_rem),
    .a_i(top1), .b_i(top0), .done_o(div_done), .result_o(div_res)
  );

  assign can_emit = !ov_q || out_if.ready;
  assign full = (cnt_q == CntW'(StackDepth));

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; acc_d = acc_q;
    in_num_d = in_num_q; in_text_d = in_text_q; in_cmt_d = in_cmt_q;
    pend_d = pend_q; pend_v_d = pend_v_q; prv_d = prv_q;
    ov_d = ov_q && !out_if.ready;
    ok_d = ok_q; oval_d = oval_q; och_d = och_q;
    ctl.op = CELL_HOLD; ctl.push_val = acc_q;
    div_start = 1'b0; div_rem = 1'b0;
    in_if.ready = 1'b0;
    acc_in = 1'b0;
    c = pend_v_q ? pend_q : in_if.prog_char;

    case (state_q)
      ST_RUN: begin
        in_if.ready = can_emit && !pend_v_q;
        acc_in = (in_if.valid && in_if.ready) || pend_v_q;
        if (acc_in && can_emit) begin
          pend_v_d = 1'b0;
          if (!pend_v_q && in_cmt_q && c != ChNl) begin
            // drop comment body
          end else if (!pend_v_q && !in_cmt_q && c == ChTilde) begin
            in_cmt_d = 1'b1;
          end else begin
            in_cmt_d = 1'b0;
            if (in_text_q) begin
              if (c == ChQuote) in_text_d = 1'b0;
              else begin
                ov_d = 1'b1; ok_d = KIND_CHAR; oval_d = '0;
                och_d = (c == ChBang) ? ChNl : c;
              end
            end else if (c >= ChZero && c <= ChNine) begin
              in_num_d = 1'b1;
              acc_d = (in_num_q ? acc_q * 32'd10 : 32'd0) + {24'd0, c - ChZero};
            end else if (in_num_q) begin
              // push the finished number if not full, then replay the held character
              in_num_d = 1'b0;
              acc_d = '0;
              if (!full) begin
                ctl.op = CELL_PUSH;
                cnt_d = cnt_q + 1'b1;
              end
              pend_d = c; pend_v_d = 1'b1; prv_d = in_if.read_value;
            end else begin
              case (c)
                ChPlus, ChMinus, ChStar, ChSlash, ChPct: begin
                  if (cnt_q < CntW'(2)) begin
                    cnt_d = '0; state_d = ST_HALT;
                    ov_d = 1'b1; ok_d = KIND_UNDERFLOW; oval_d = '0; och_d = '0;
                  end else if (c == ChSlash || c == ChPct) begin
                    if (top0 == 32'd0) begin
                      ctl.op = CELL_POP2; ctl.push_val = '0;
                      cnt_d = cnt_q - CntW'(2);
                      acc_d = '0;
                      state_d = ST_PUSH;
                      ov_d = 1'b1; ok_d = KIND_DIVZERO; oval_d = '0; och_d = '0;
                    end else begin
                      div_start = 1'b1; div_rem = (c == ChPct);
                      state_d = ST_DIV;
                    end
                  end else begin
                    ctl.op = CELL_POP2;
                    cnt_d = cnt_q - CntW'(2);
                    ctl.push_val = (c == ChPlus) ? top1 + top0 :
                                   (c == ChMinus) ? top1 - top0 : top1 * top0;
                    state_d = ST_PUSH;
                    acc_d = ctl.push_val;
                  end
                end
                ChQuery: begin
                  if (!full) begin
                    ctl.op = CELL_PUSH;
                    ctl.push_val = pend_v_q ? prv_q : in_if.read_value;
                    cnt_d = cnt_q + 1'b1;
                  end
                end
                ChBang: begin
                  ov_d = 1'b1; och_d = '0;
                  if (cnt_q == '0) begin
                    ok_d = KIND_UNDERFLOW; oval_d = '0; state_d = ST_HALT;
                  end else begin
                    ok_d = KIND_NUMBER; oval_d = top0;
                    ctl.op = CELL_POP; cnt_d = cnt_q - 1'b1;
                  end
                end
                ChQuote: in_text_d = 1'b1;
                ChDol: begin
                  ov_d = 1'b1; ok_d = KIND_HALT; oval_d = '0; och_d = '0;
                  state_d = ST_HALT;
                end
                default: ;
              endcase
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          acc_d = div_res;
          ctl.op = CELL_POP2;
          cnt_d = cnt_q - CntW'(2);
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        // push the result held in acc over the two popped operands
        ctl.op = CELL_PUSH; ctl.push_val = acc_q;
        cnt_d = cnt_q + 1'b1;
        acc_d = '0;
        state_d = ST_RUN;
      end
      ST_HALT: in_if.ready = 1'b1;
      default: state_d = ST_HALT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      cnt_q <= '0;
      in_num_q <= 1'b0; in_text_q <= 1'b0; in_cmt_q <= 1'b0;
      pend_v_q <= 1'b0; ov_q <= 1'b0;
      acc_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      in_num_q <= in_num_d; in_text_q <= in_text_d; in_cmt_q <= in_cmt_d;
      pend_v_q <= pend_v_d; ov_q <= ov_d;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d; prv_q <= prv_d;
    ok_q <= ok_d; oval_q <= oval_d; och_q <= och_d;
  end

  assign out_if.valid = ov_q;
  assign out_if.out_kind = ok_q;
  assign out_if.out_value = oval_q;
  assign out_if.out_char = och_q;

  `RPN_ASSERT_IMPL(a_cnt_max, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(StackDepth))
  `RPN_ASSERT_IMPL(a_no_in_busy, clk_i, rst_ni, state_q == ST_DIV || state_q == ST_PUSH, !in_if.ready)
  `RPN_ASSERT_NEXT(a_halt_stays, clk_i, rst_ni, state_q == ST_HALT, state_q == ST_HALT)
  `RPN_ASSERT_NEXT(a_push_back, clk_i, rst_ni, state_q == ST_PUSH, state_q == ST_RUN)
endmodule

// File: design/rpn_cell.sv
`timescale 1ns / 1ps
// One stack slot; the top of stack sits in cell 0.
module rpn_cell (
  input  logic                clk_i,
  input  rpn_pkg::cell_ctl_t  ctl_i,
  input  logic [31:0]         above_i,
  input  logic [31:0]         below1_i,
  input  logic [31:0]         below2_i,
  output logic [31:0]         value_o
);
  import rpn_pkg::*;

  logic [31:0] value_q, value_d;

  always_comb begin
    case (ctl_i.op)
      CELL_PUSH: value_d = above_i;
      CELL_POP:  value_d = below1_i;
      CELL_POP2: value_d = below2_i;
      default:   value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
endmodule

// File: design/rpn_stack.sv
`timescale 1ns / 1ps
// Row of shift cells; push moves every slot down one, pops move up.
module rpn_stack (
  input  logic               clk_i,
  input  rpn_pkg::cell_ctl_t ctl_i,
  output logic [31:0]        top0_o,
  output logic [31:0]        top1_o
);
  import rpn_pkg::*;

  logic [31:0] val [StackDepth];

  for (genvar g = 0; g < StackDepth; g++) begin : g_cell
    logic [31:0] above, below1, below2;
    if (g == 0) begin : g_top
      assign above = ctl_i.push_val;
    end else begin : g_mid
      assign above = val[g-1];
    end
    if (g + 1 < StackDepth) begin : g_b1
      assign below1 = val[g+1];
    end else begin : g_b1z
      assign below1 = val[g];
    end
    if (g + 2 < StackDepth) begin : g_b2
      assign below2 = val[g+2];
    end else begin : g_b2z
      assign below2 = val[g];
    end
    rpn_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl_i),
      .above_i (above),
      .below1_i(below1),
      .below2_i(below2),
      .value_o (val[g])
    );
  end

  assign top0_o = val[0];
  assign top1_o = val[1];
endmodule

// File: design/rpn_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, signed truncating.
module rpn_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        want_rem_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] result_o
);
  import rpn_pkg::*;

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d, rem_q, rem_d, div_q, div_d;
  logic        neg_q_q, neg_q_d, neg_r_q, neg_r_d, rem_sel_q, rem_sel_d;
  logic [32:0] trial;
  logic [31:0] shifted;

  always_comb begin
    busy_d = busy_q; cnt_d = cnt_q; quo_d = quo_q; rem_d = rem_q; div_d = div_q;
    neg_q_d = neg_q_q; neg_r_d = neg_r_q; rem_sel_d = rem_sel_q;
    shifted = {rem_q[30:0], quo_q[31]};
    trial = {1'b0, shifted} - {1'b0, div_q};
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = 6'(DivSteps);
      quo_d = a_i[31] ? (32'd0 - a_i) : a_i;
      div_d = b_i[31] ? (32'd0 - b_i) : b_i;
      rem_d = '0;
      neg_q_d = a_i[31] ^ b_i[31];
      neg_r_d = a_i[31];
      rem_sel_d = want_rem_i;
    end else if (busy_q) begin
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        cnt_d = cnt_q - 6'd1;
        if (!trial[32]) begin
          rem_d = trial[31:0];
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = shifted;
          quo_d = {quo_q[30:0], 1'b0};
        end
      end
    end
  end

  // Negating a wrapped INT_MIN quotient yields INT_MIN again, as required.
  assign result_o = rem_sel_q ? (neg_r_q ? 32'd0 - rem_q : rem_q)
                              : (neg_q_q ? 32'd0 - quo_q : quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; div_q <= div_d;
    neg_q_q <= neg_q_d; neg_r_q <= neg_r_d; rem_sel_q <= rem_sel_d;
  end
endmodule

// File: test/rpn_result_checker.sv
`timescale 1ns / 1ps
module rpn_result_checker (
  input  logic clk_i,
  input  logic rst_ni,
  rpn_in_if    in_mon,
  rpn_out_if   out_mon,
  output int   fail_count_o,
  output int   pending_o
);
  import rpn_pkg::*;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic [7:0]  chr;
  } calc_result_t;

  calc_result_t result_q[$];
  logic [31:0]  stack_mem[StackDepth];
  int unsigned  depth;
  logic [31:0]  acc;
  logic         in_num, in_txt, in_cmt, stopped;
  int           fails;

  assign fail_count_o = fails;
  assign pending_o    = result_q.size();

  task automatic push_stack(input logic [31:0] v);
    if (depth < StackDepth) begin
      stack_mem[depth] = v;
      depth++;
    end
  endtask

  task automatic emit(input kind_e k, input logic [31:0] v, input logic [7:0] c);
    calc_result_t r;
    r.kind  = k;
    r.value = v;
    r.chr   = c;
    result_q.push_back(r);
  endtask

  task automatic interpret_char(input logic [7:0] c, input logic [31:0] rv);
    logic [31:0] a, b, q;
    int sa, sb;
    if (stopped) return;
    if (in_cmt) begin
      if (c != ChNl) return;
      in_cmt = 1'b0;
    end else if (c == ChTilde) begin
      in_cmt = 1'b1;
      return;
    end
    if (in_txt) begin
      if (c == ChQuote) in_txt = 1'b0;
      else emit(KIND_CHAR, '0, (c == ChBang) ? ChNl : c);
      return;
    end
    if (c >= ChZero && c <= ChNine) begin
      if (!in_num) begin
        in_num = 1'b1;
        acc = '0;
      end
      acc = acc * 32'd10 + 32'(c - ChZero);
      return;
    end
    if (in_num) begin
      in_num = 1'b0;
      push_stack(acc);
      acc = '0;
    end
    case (c)
      ChPlus, ChMinus, ChStar, ChSlash, ChPct: begin
        if (depth < 2) begin
          depth = 0;
          stopped = 1'b1;
          emit(KIND_UNDERFLOW, '0, '0);
          return;
        end
        depth--;
        b = stack_mem[depth];
        depth--;
        a = stack_mem[depth];
        if (c == ChPlus) push_stack(a + b);
        else if (c == ChMinus) push_stack(a - b);
        else if (c == ChStar) push_stack(a * b);
        else if (b == '0) begin
          push_stack('0);
          emit(KIND_DIVZERO, '0, '0);
        end else begin
          // quotient overflow wraps, remainder is zero
          if (a == 32'h8000_0000 && b == 32'hffff_ffff) begin
            q = (c == ChPct) ? '0 : a;
          end else begin
            sa = a;
            sb = b;
            q = (c == ChPct) ? 32'(sa % sb) : 32'(sa / sb);
          end
          push_stack(q);
        end
      end
      ChQuery: push_stack(rv);
      ChBang: begin
        if (depth == 0) begin
          stopped = 1'b1;
          emit(KIND_UNDERFLOW, '0, '0);
        end else begin
          depth--;
          emit(KIND_NUMBER, stack_mem[depth], '0);
        end
      end
      ChQuote: in_txt = 1'b1;
      ChDol: begin
        stopped = 1'b1;
        emit(KIND_HALT, '0, '0);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    calc_result_t exp_r;
    if (!rst_ni) begin
      depth   = 0;
      acc     = '0;
      in_num  = 1'b0;
      in_txt  = 1'b0;
      in_cmt  = 1'b0;
      stopped = 1'b0;
      fails   = 0;
      result_q.delete();
    end else begin
      // compare first: a result never leaves in the cycle its input arrives
      if (out_mon.valid && out_mon.ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result kind %0d", out_mon.out_kind);
          fails++;
        end else begin
          exp_r = result_q.pop_front();
          if (out_mon.out_kind !== exp_r.kind) begin
            $error("out_kind expected %0d actual %0d", exp_r.kind, out_mon.out_kind);
            fails++;
          end
          if (out_mon.out_value !== exp_r.value) begin
            $error("out_value expected %0d actual %0d",
                   $signed(exp_r.value), out_mon.out_value);
            fails++;
          end
          if (out_mon.out_char !== exp_r.chr) begin
            $error("out_char expected %0d actual %0d", exp_r.chr, out_mon.out_char);
            fails++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        interpret_char(in_mon.prog_char, in_mon.read_value);
    end
  end
endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
module tb;
  import rpn_pkg::*;

  localparam int NumItems   = 1400;
  localparam int CycleLimit = 1000000;
  localparam int DrainWait  = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  int   sent = 0;
  int   fail_count, pending;
  int   depth_est = 0;
  logic last_digit = 1'b0;

  rpn_in_if  in_if ();
  rpn_out_if out_if ();

  rpn_char_stack_interpreter uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  rpn_result_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL rpn_char_stack_interpreter");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Random backpressure on results, with long stretches fully ready.
  initial begin
    int n;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      n = $urandom_range(1, 40);
      out_if.ready <= 1'b1;
      repeat (n) @(posedge clk_i);
      n = pick_gap();
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  task automatic send(input logic [7:0] c, input logic [31:0] rv);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.prog_char  <= c;
    in_if.read_value <= rv;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send(s[i], $urandom());
  endtask

  function automatic bit is_special(input logic [7:0] c);
    return (c >= ChZero && c <= ChNine) || c == ChPlus || c == ChMinus ||
           c == ChStar || c == ChSlash || c == ChPct || c == ChQuery ||
           c == ChBang || c == ChQuote || c == ChDol || c == ChTilde;
  endfunction

  task automatic send_number();
    int n;
    if (last_digit) send(" ", $urandom());
    n = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 12);
    for (int i = 0; i < n; i++)
      send(ChZero + 8'($urandom_range(0, 9)), $urandom());
    if (depth_est < StackDepth) depth_est++;
    last_digit = 1'b1;
  endtask

  task automatic random_token();
    int r, n;
    logic [7:0] c, ops[5];
    ops = '{ChPlus, ChMinus, ChStar, ChSlash, ChPct};
    r = $urandom_range(0, 99);
    if (r < 30 || (r >= 40 && r < 60 && depth_est < 2) ||
        (r >= 60 && r < 72 && depth_est < 1)) begin
      send_number();
      return;
    end
    if (r < 40) begin
      send(ChQuery, $urandom());
      if (depth_est < StackDepth) depth_est++;
    end else if (r < 60) begin
      send(ops[$urandom_range(0, 4)], $urandom());
      depth_est--;
    end else if (r < 72) begin
      send(ChBang, $urandom());
      depth_est--;
    end else if (r < 80) begin
      send(ChQuote, $urandom());
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) begin
        do c = 8'($urandom_range(0, 255)); while (c == ChQuote || c == ChTilde);
        send(c, $urandom());
      end
      send(ChQuote, $urandom());
    end else if (r < 87) begin
      // comment may split a digit run; the newline then ends it
      send(ChTilde, $urandom());
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        do c = 8'($urandom_range(0, 255)); while (c == ChNl);
        send(c, $urandom());
      end
      send(ChNl, $urandom());
    end else begin
      do c = 8'($urandom_range(0, 255)); while (is_special(c));
      send(c, $urandom());
    end
    last_digit = 1'b0;
  endtask

  initial begin
    in_if.valid      <= 1'b0;
    in_if.prog_char  <= '0;
    in_if.read_value <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_str("7 3+! 4 9-! 6 7*! ");
    send(ChQuery, -32'sd7);
    send_str("2/!");
    send(ChQuery, -32'sd7);
    send_str("2%! 5 0/! 5 0%! ");
    send(ChQuery, 32'h8000_0000);
    send(ChQuery, 32'hffff_ffff);
    send_str("/!");
    send(ChQuery, 32'h8000_0000);
    send(ChQuery, 32'hffff_ffff);
    send_str("%! 99999999999 ! 12~zz\n! \"a!$1+~x\nb\" ");
    send(8'hff, 32'h7fff_ffff);
    send(8'h00, 32'h0);
    // overfill the stack, then drain
    for (int i = 0; i < StackDepth + 3; i++) send_str("1 ");
    for (int i = 0; i < StackDepth; i++) send(ChBang, $urandom());
    depth_est = 0;

    while (sent < NumItems) begin
      random_token();
      if (sent > NumItems / 2 && sent < NumItems / 2 + 8) begin
        in_if.valid <= 1'b0;
        wait (pending == 0);
        @(posedge clk_i);
      end
    end

    if ($urandom_range(0, 1) == 0) begin
      send_str(" 12$");
    end else begin
      for (int i = 0; i <= depth_est + 1 && i <= StackDepth + 1; i++)
        send(ChBang, $urandom());
      send(ChDol, $urandom());
    end
    in_if.valid <= 1'b0;

    wait (pending == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS rpn_char_stack_interpreter");
    end else begin
      $display("FAIL rpn_char_stack_interpreter");
    end
    $finish;
  end
endmodule
